// File: src/bsdc_pkg.sv
// Package: shared constants, types and the hash step of the slot directory.
`timescale 1ns / 1ps
package bsdc_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 64;
    localparam int SUM_W  = 64;

    localparam logic [SUM_W-1:0] FNV_BASIS   = 64'hcbf29ce484222325;
    localparam logic [SUM_W-1:0] FNV_PRIME_LO = 64'h00000000000001b3;
    localparam int               FNV_PRIME_SH = 40;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_EVICT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_ABSENT   = 2'd1,
        STS_NO_SLOT  = 2'd2,
        STS_MISMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [KEY_W-1:0] key;
        logic [7:0]       data_byte;
        logic             last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [5:0]       slot;
        logic [6:0]       free_count;
        logic [SUM_W-1:0] checksum;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DECIDE,
        ST_POP,
        ST_HASH,
        ST_FINISH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic scan_step;
        logic open_blk;
        logic evict;
        logic pop;
        logic hash;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] new_act;
        logic [1:0] act;
        logic       last;
        logic       in_block;
        logic       match;
        logic       scan_end;
        logic       found;
        logic       depth_zero;
        logic       out_free;
    } sts_t;

    // One FNV-1a step; the prime is 2^40 + 0x1b3.
    function automatic logic [SUM_W-1:0] fnv_step(input logic [SUM_W-1:0] h,
                                                  input logic [7:0] b);
        logic [SUM_W-1:0] x;
        logic [SUM_W-1:0] lo;
        x  = h ^ {{(SUM_W-8){1'b0}}, b};
        lo = x * FNV_PRIME_LO;
        return (x << FNV_PRIME_SH) + lo;
    endfunction

endpackage

// File: src/block_slot_directory_checksum_top.sv
// Top level of the block slot directory with FNV-1a 64 checking.
`timescale 1ns / 1ps
// Maps 64-bit block keys to slots and checks block contents with FNV-1a 64.
// Items are taken one at a time. A byte inside an open block goes straight
// to the hash step; lookup, evict and the first byte of a block search the key
// memory one slot at a time (registered read, then compare) from slot 0 and
// stop at a match or at the last slot, and a first write byte whose key is
// absent then pops a free slot when the stack is not empty. A last byte
// posts its result from a finish state. A result waiting in the output
// register holds the controller when the next result is ready to post, so no
// further input is taken until the register drains. Writing active_slots
// empties the directory at once; no clearing pass is needed after reset.
module block_slot_directory_checksum_top import bsdc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    bsdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bsdc_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// File: src/bsdc_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module bsdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bsdc_ctrl.sv
// Controller state machine sequencing search, allocation, hashing and results.
`timescale 1ns / 1ps
module bsdc_ctrl import bsdc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (sts.new_act == ACT_LOOKUP || sts.new_act == ACT_EVICT
                        || !sts.in_block) begin
                        state_next = ST_SRCH_RD;
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_SRCH_RD:  state_next = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (sts.match || sts.scan_end) begin
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_DECIDE: begin
                if (sts.act == ACT_LOOKUP || sts.act == ACT_EVICT) begin
                    state_next = ST_EMIT;
                end else if (!sts.found && sts.act == ACT_WRITE && !sts.depth_zero) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_HASH;
                end
            end
            ST_POP:  state_next = ST_HASH;
            ST_HASH: state_next = sts.last ? ST_FINISH : ST_IDLE;
            ST_FINISH, ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_SRCH_CMP: cmd.scan_step = 1'b1;
            ST_DECIDE: begin
                cmd.evict    = (sts.act == ACT_EVICT);
                cmd.open_blk = (sts.act == ACT_WRITE || sts.act == ACT_READ);
            end
            ST_POP:    cmd.pop    = 1'b1;
            ST_HASH:   cmd.hash   = 1'b1;
            ST_FINISH: cmd.finish = sts.out_free;
            ST_EMIT:   cmd.emit   = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: src/bsdc_dpath.sv
// Datapath: directory stores, free stack, running hash and result register.
`timescale 1ns / 1ps
module bsdc_dpath import bsdc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    output out_item_t m_data,
    output logic      m_valid,
    input  logic      m_ready,
    input  logic      cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  cmd_t      cmd,
    output sts_t      sts
);

    in_item_t          item_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] hit_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [SLOTS-1:0]  fvalid_reg;
    logic [CNT_W-1:0]  depth_reg;
    logic [CNT_W-1:0]  active_reg;
    logic              in_block_reg;
    logic              is_read_reg;
    logic [1:0]        fault_reg;
    logic [SLOT_W-1:0] bslot_reg;
    logic [SUM_W-1:0]  hash_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [KEY_W-1:0]  key_rdata;
    logic [SLOT_W-1:0] free_rdata;
    logic [SUM_W-1:0]  sum_rdata;
    logic [SLOT_W-1:0] top_idx;
    logic [CNT_W-1:0]  top_dflt;
    logic [SLOT_W-1:0] pop_slot;
    logic [SLOT_W-1:0] push_idx;
    logic              push_ok;
    logic [CNT_W-1:0]  cfg_val;
    logic              cks_we;
    logic [1:0]        fin_status;

    assign top_idx  = SLOT_W'(depth_reg - 1'b1);
    assign top_dflt = active_reg - depth_reg;
    assign pop_slot = fvalid_reg[top_idx] ? free_rdata : top_dflt[SLOT_W-1:0];
    assign push_idx = depth_reg[SLOT_W-1:0];
    assign push_ok  = found_reg && (depth_reg < CNT_W'(SLOTS));
    assign cks_we   = cmd.finish && (fault_reg == 2'd0) && !is_read_reg;

    // Clamp the register value into 1..SLOTS.
    always_comb begin
        if (cfg_wr_data == 7'd0) begin
            cfg_val = CNT_W'(1);
        end else if (CNT_W'(cfg_wr_data) > CNT_W'(SLOTS)) begin
            cfg_val = CNT_W'(SLOTS);
        end else begin
            cfg_val = CNT_W'(cfg_wr_data);
        end
    end

    always_comb begin
        if (fault_reg != 2'd0) begin
            fin_status = fault_reg;
        end else if (is_read_reg && hash_reg != sum_rdata) begin
            fin_status = STS_MISMATCH;
        end else begin
            fin_status = STS_OK;
        end
    end

    bsdc_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .aclk  (aclk),
        .we    (cmd.pop),
        .waddr (pop_slot),
        .wdata (item_reg.key),
        .raddr (cnt_reg),
        .rdata (key_rdata)
    );

    bsdc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_free_ram (
        .aclk  (aclk),
        .we    (cmd.evict && push_ok),
        .waddr (push_idx),
        .wdata (hit_reg),
        .raddr (top_idx),
        .rdata (free_rdata)
    );

    bsdc_ram #(.WIDTH(SUM_W), .DEPTH(SLOTS)) u_sum_ram (
        .aclk  (aclk),
        .we    (cks_we),
        .waddr (bslot_reg),
        .wdata (hash_reg),
        .raddr (bslot_reg),
        .rdata (sum_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            found_reg    <= 1'b0;
            hit_reg      <= '0;
            valid_reg    <= '0;
            fvalid_reg   <= '0;
            depth_reg    <= CNT_W'(SLOTS);
            active_reg   <= CNT_W'(SLOTS);
            in_block_reg <= 1'b0;
            is_read_reg  <= 1'b0;
            fault_reg    <= 2'd0;
            bslot_reg    <= '0;
            hash_reg     <= FNV_BASIS;
            m_valid_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            // Reinitialise directory and free stack.
            valid_reg    <= '0;
            fvalid_reg   <= '0;
            depth_reg    <= cfg_val;
            active_reg   <= cfg_val;
            in_block_reg <= 1'b0;
            is_read_reg  <= 1'b0;
            fault_reg    <= 2'd0;
            bslot_reg    <= '0;
            hash_reg     <= FNV_BASIS;
        end else begin
            if (cmd.finish || cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.take) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                if (sts.match) begin
                    found_reg <= 1'b1;
                    hit_reg   <= cnt_reg;
                end else if (!sts.scan_end) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.evict && found_reg) begin
                valid_reg[hit_reg] <= 1'b0;
                if (push_ok) begin
                    fvalid_reg[push_idx] <= 1'b1;
                    depth_reg            <= depth_reg + 1'b1;
                end
            end
            if (cmd.open_blk) begin
                in_block_reg <= 1'b1;
                is_read_reg  <= (item_reg.action == ACT_READ);
                bslot_reg    <= found_reg ? hit_reg : '0;
                if (found_reg) begin
                    fault_reg <= STS_OK;
                end else if (item_reg.action == ACT_READ) begin
                    fault_reg <= STS_ABSENT;
                end else if (depth_reg == '0) begin
                    fault_reg <= STS_NO_SLOT;
                end else begin
                    fault_reg <= STS_OK;
                end
            end
            if (cmd.pop) begin
                depth_reg           <= depth_reg - 1'b1;
                bslot_reg           <= pop_slot;
                valid_reg[pop_slot] <= 1'b1;
            end
            if (cmd.hash) begin
                hash_reg <= fnv_step(hash_reg, item_reg.data_byte);
            end
            if (cmd.finish) begin
                m_data_reg.status     <= fin_status;
                m_data_reg.slot       <= (fault_reg != 2'd0) ? '0 : bslot_reg;
                m_data_reg.free_count <= depth_reg;
                m_data_reg.checksum   <= hash_reg;
                in_block_reg          <= 1'b0;
                is_read_reg           <= 1'b0;
                fault_reg             <= 2'd0;
                bslot_reg             <= '0;
                hash_reg              <= FNV_BASIS;
            end
            if (cmd.emit) begin
                m_data_reg.status     <= found_reg ? STS_OK : STS_ABSENT;
                m_data_reg.slot       <= found_reg ? hit_reg : '0;
                m_data_reg.free_count <= depth_reg;
                m_data_reg.checksum   <= '0;
            end
        end
    end

    always_comb begin
        sts.new_act    = s_data.action;
        sts.act        = item_reg.action;
        sts.last       = item_reg.last_byte;
        sts.in_block   = in_block_reg;
        sts.match      = valid_reg[cnt_reg] && (key_rdata == item_reg.key);
        sts.scan_end   = (cnt_reg == SLOT_W'(SLOTS - 1));
        sts.found      = found_reg;
        sts.depth_zero = (depth_reg == '0);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: dv/block_slot_directory_checksum_top_tb.sv
// Testbench for the block slot directory: predicts each result and checks it in order.
`timescale 1ns / 1ps
module block_slot_directory_checksum_top_tb;
    import bsdc_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_wr_en = 1'b0;
    logic [6:0] cfg_wr_data = '0;

    block_slot_directory_checksum_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // directory mirror
    int unsigned      dir_slots;
    logic [63:0]      dir_key [SLOTS];
    logic             dir_used [SLOTS];
    logic [63:0]      dir_sum [SLOTS];
    int unsigned      stack_slot [SLOTS];
    int unsigned      stack_depth;
    logic             blk_open;
    logic             blk_read;
    int unsigned      blk_slot;
    logic [1:0]       blk_fault;
    logic [63:0]      blk_hash;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    logic [63:0] known_keys [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned idle_pct = 20;

    function automatic logic [63:0] hash_byte(logic [63:0] h, logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x * 64'h100000001b3;
    endfunction

    function automatic int find_slot(logic [63:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (dir_used[i] && dir_key[i] == k) return i;
        return -1;
    endfunction

    task automatic reset_directory(int unsigned n);
        dir_slots = (n == 0) ? 1 : (n > SLOTS ? SLOTS : n);
        for (int i = 0; i < SLOTS; i++) dir_used[i] = 1'b0;
        for (int i = 0; i < dir_slots; i++) stack_slot[i] = dir_slots - 1 - i;
        stack_depth = dir_slots;
        blk_open = 1'b0; blk_read = 1'b0; blk_slot = 0; blk_fault = 2'd0;
        blk_hash = FNV_BASIS;
    endtask

    task automatic predict_directory(in_item_t it);
        out_item_t r;
        int s;
        s = find_slot(it.key);
        r = '0;
        if (it.action == ACT_LOOKUP || it.action == ACT_EVICT) begin
            if (s >= 0) begin
                if (it.action == ACT_EVICT) begin
                    dir_used[s] = 1'b0;
                    if (stack_depth < SLOTS) begin
                        stack_slot[stack_depth] = s;
                        stack_depth++;
                    end
                end
                r.status = STS_OK; r.slot = 6'(s);
            end else begin
                r.status = STS_ABSENT;
            end
            r.free_count = 7'(stack_depth);
            expected_results = {expected_results, r};
            return;
        end
        if (!blk_open) begin
            blk_open = 1'b1;
            blk_read = (it.action == ACT_READ);
            blk_fault = 2'd0; blk_slot = 0; blk_hash = FNV_BASIS;
            if (s >= 0) blk_slot = s;
            else if (blk_read) blk_fault = STS_ABSENT;
            else if (stack_depth == 0) blk_fault = STS_NO_SLOT;
            else begin
                stack_depth--;
                blk_slot = stack_slot[stack_depth];
                dir_key[blk_slot] = it.key;
                dir_used[blk_slot] = 1'b1;
            end
        end
        blk_hash = hash_byte(blk_hash, it.data_byte);
        if (!it.last_byte) return;
        r.status = blk_fault;
        r.slot = (blk_fault != 2'd0) ? 6'd0 : 6'(blk_slot);
        r.checksum = blk_hash;
        if (blk_fault == 2'd0) begin
            if (blk_read) begin
                if (blk_hash != dir_sum[blk_slot]) r.status = STS_MISMATCH;
            end else begin
                dir_sum[blk_slot] = blk_hash;
            end
        end
        r.free_count = 7'(stack_depth);
        blk_open = 1'b0;
        expected_results = {expected_results, r};
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_directory(s_data);
                void'(pending_items.pop_front());
            end
            if ((!s_valid || s_ready) ) begin
                if (pending_items.size() > (s_valid && s_ready ? 0 : 0) &&
                    $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_data.checksum, 64'd0);
                end else begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (m_data.status != e.status)
                        report_mismatch("status", 64'(m_data.status), 64'(e.status));
                    if (m_data.slot != e.slot)
                        report_mismatch("slot", 64'(m_data.slot), 64'(e.slot));
                    if (m_data.free_count != e.free_count)
                        report_mismatch("free_count", 64'(m_data.free_count),
                                        64'(e.free_count));
                    if (m_data.checksum != e.checksum)
                        report_mismatch("checksum", m_data.checksum, e.checksum);
                end
            end
            m_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_item(action_t a, logic [63:0] k, logic [7:0] b, logic l);
        in_item_t it;
        it.action = a; it.key = k; it.data_byte = b; it.last_byte = l;
        pending_items = {pending_items, it};
    endtask

    // whole block of random bytes
    task automatic queue_block(action_t a, logic [63:0] k, int unsigned len);
        for (int i = 0; i < len; i++)
            queue_item(a, k, 8'($urandom_range(255)), i == len - 1);
    endtask

    // replay a block whose bytes are remembered so reads can match
    logic [7:0] saved_bytes [logic [63:0]][$];

    task automatic queue_write_saved(logic [63:0] k, int unsigned len);
        logic [7:0] b;
        saved_bytes[k] = {};
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            saved_bytes[k] = {saved_bytes[k], b};
            queue_item(ACT_WRITE, k, b, i == len - 1);
        end
        known_keys = {known_keys, k};
    endtask

    task automatic queue_read_saved(logic [63:0] k);
        int unsigned n;
        n = saved_bytes[k].size();
        for (int i = 0; i < n; i++)
            queue_item(ACT_READ, k, saved_bytes[k][i], i == n - 1);
    endtask

    task automatic drain_and_configure(logic [6:0] v);
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        reset_directory(v);
        known_keys = {};
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned n;
        int unsigned pick;
        logic [63:0] k;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (n > count / 3 && n < count / 2) idle_pct = 0;
            else idle_pct = 20;
            if (known_keys.size() > 0 && pick < 30) begin
                k = known_keys[$urandom_range(known_keys.size() - 1)];
                if ($urandom_range(3) == 0)
                    queue_block(ACT_READ, k, $urandom_range(1, 4));
                else queue_read_saved(k);
                n += 3;
            end else if (pick < 60) begin
                k = ($urandom_range(9) == 0) ? '1 : rand_key();
                queue_write_saved(k, $urandom_range(1, 6));
                n += 3;
            end else if (pick < 75) begin
                k = (known_keys.size() > 0 && pick < 70)
                    ? known_keys[$urandom_range(known_keys.size() - 1)] : rand_key();
                queue_item(ACT_LOOKUP, k, 8'($urandom_range(255)), 1'($urandom_range(1)));
                n++;
            end else if (pick < 90) begin
                k = (known_keys.size() > 0 && pick < 87)
                    ? known_keys[$urandom_range(known_keys.size() - 1)] : rand_key();
                queue_item(ACT_EVICT, k, 8'($urandom_range(255)), 1'($urandom_range(1)));
                n++;
            end else begin
                // noise: mixed-kind block and unknown-key read
                queue_item(ACT_WRITE, rand_key(), 8'($urandom_range(255)), 1'b0);
                queue_item(ACT_READ, rand_key(), 8'($urandom_range(255)), 1'b1);
                queue_block(ACT_READ, rand_key(), $urandom_range(1, 3));
                n += 3;
            end
            wait (pending_items.size() < 16);
        end
    endtask

    initial begin
        reset_directory(64);
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, all actions, absent keys, mixed block, lookup inside block
        queue_item(ACT_LOOKUP, '0, 8'h00, 1'b0);
        queue_item(ACT_EVICT, '1, 8'hff, 1'b1);
        queue_block(ACT_READ, 64'h5555_aaaa_5555_aaaa, 2);
        queue_item(ACT_WRITE, '1, 8'hff, 1'b1);
        queue_item(ACT_WRITE, '0, 8'h00, 1'b0);
        queue_item(ACT_LOOKUP, '0, 8'h00, 1'b0);
        queue_item(ACT_READ, 64'h1234, 8'h80, 1'b1);
        queue_item(ACT_READ, '0, 8'h00, 1'b1);
        queue_item(ACT_LOOKUP, '1, 8'h00, 1'b0);
        queue_item(ACT_WRITE, 64'haaaa_5555_aaaa_5555, 8'h3c, 1'b0);
        queue_item(ACT_EVICT, 64'haaaa_5555_aaaa_5555, 8'h00, 1'b0);
        queue_item(ACT_WRITE, 64'h0, 8'hc3, 1'b1);
        queue_item(ACT_EVICT, '0, 8'h00, 1'b0);
        queue_item(ACT_EVICT, '0, 8'h00, 1'b0);
        random_phase(300);

        // one slot: exhaust the free stack, including a blocked write
        drain_and_configure(7'd1);
        queue_write_saved(64'h11, 2);
        queue_block(ACT_WRITE, 64'h22, 3);
        queue_read_saved(64'h11);
        queue_item(ACT_EVICT, 64'h11, 8'h00, 1'b0);
        random_phase(150);

        drain_and_configure(7'd0);
        random_phase(100);
        drain_and_configure(7'd127);
        random_phase(150);
        drain_and_configure(7'd3);
        random_phase(150);
        drain_and_configure(7'd64);
        random_phase(200);

        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge aclk);
        $display("run covered lookups, evictions, written and read-back blocks");
        $display("across active slot counts 64, 1, 0, 127, 3 and 64: %0d results checked",
                 results_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

// File: block_slot_directory_checksum_top.f
src/bsdc_pkg.sv
src/bsdc_ram.sv
src/bsdc_ctrl.sv
src/bsdc_dpath.sv
src/block_slot_directory_checksum_top.sv
dv/block_slot_directory_checksum_top_tb.sv
